>>> hdl/lzss_pkg.sv
package lzss_pkg;

  localparam int WIN_AW    = 12;
  localparam int WIN_SIZE  = 1 << WIN_AW;
  localparam int MAX_MATCH = 18;
  localparam int FILL_W    = WIN_AW + 1;
  localparam int LEN_W     = 5;

  localparam logic [WIN_AW-1:0] WP_RESET  = WIN_AW'(WIN_SIZE - MAX_MATCH);
  localparam logic [LEN_W-1:0]  MIN_MATCH = LEN_W'(3);
  localparam logic [7:0]        SPACE_CHR = 8'h20;
  localparam logic [7:0]        FLAG_FILL = 8'hFF;

  // what an accepted input byte turns into
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LIT  = 2'd1;
  localparam logic [1:0] KIND_REF  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       limit_reached;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic emit;
    logic emit_lit;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       in_last;
    logic       held_last;
    logic       out_free;
    logic       run_end;
  } dp_sts_t;

endpackage

>>> hdl/lzss_ctrl.sv
module lzss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzss_pkg::dp_sts_t  sts,
  output lzss_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_LIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.kind == lzss_pkg::KIND_LIT) begin
            state_nxt = ST_LIT;
          end else if (sts.kind == lzss_pkg::KIND_REF) begin
            state_nxt = ST_RD;
          end else begin
            cmd.clear = sts.in_last;
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.run_end) begin
            cmd.clear = sts.held_last;
            state_nxt = ST_IDLE;
          end else begin
            // next window read overlaps this write
            cmd.rd_issue = 1'b1;
          end
        end
      end
      ST_LIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_lit = 1'b1;
          cmd.clear    = sts.held_last;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/lzss_dpath.sv
module lzss_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzss_pkg::in_item_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output lzss_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  lzss_pkg::ctl_cmd_t   cmd,
  output lzss_pkg::dp_sts_t    sts
);

  localparam int AW = lzss_pkg::WIN_AW;
  localparam int FW = lzss_pkg::FILL_W;
  localparam int LW = lzss_pkg::LEN_W;

  logic [7:0] win_mem [lzss_pkg::WIN_SIZE];

  logic [31:0]   limit_r;
  logic [31:0]   bytes_r,    bytes_nxt;
  logic          finished_r, finished_nxt;
  logic [15:0]   flag_r,     flag_nxt;
  logic          expect_r,   expect_nxt;
  logic [7:0]    off_low_r,  off_low_nxt;
  logic [AW-1:0] wp_r,       wp_nxt;
  logic [FW-1:0] fill_r,     fill_nxt;
  logic [AW-1:0] src_r,      src_nxt;
  logic [LW-1:0] left_r,     left_nxt;
  logic [7:0]    lit_r,      lit_nxt;
  logic          last_r,     last_nxt;
  logic          out_valid_r, out_valid_nxt;
  lzss_pkg::out_item_t out_r;

  logic [7:0]    rdata_r;
  logic          written_r;
  logic [7:0]    dflt_r;
  logic          fwd_r;
  logic [7:0]    fwd_data_r;

  logic          fin_eff;
  logic [1:0]    kind;
  logic [31:0]   bytes_inc;
  logic          limit_hit;
  logic [7:0]    emit_data;
  logic [AW-1:0] rd_off;

  assign fin_eff   = finished_r || (bytes_r >= limit_r);
  assign bytes_inc = bytes_r + 32'd1;
  assign limit_hit = (bytes_inc >= limit_r);
  // entries written since the last clear form one run starting at the reset position
  assign rd_off    = src_r - lzss_pkg::WP_RESET;

  always_comb begin
    kind = lzss_pkg::KIND_NONE;
    if (!fin_eff) begin
      if (expect_r) begin
        kind = lzss_pkg::KIND_REF;
      end else if (flag_r[8] && flag_r[0]) begin
        kind = lzss_pkg::KIND_LIT;
      end
    end
  end

  always_comb begin
    if (cmd.emit_lit) begin
      emit_data = lit_r;
    end else if (fwd_r) begin
      emit_data = fwd_data_r;
    end else if (written_r) begin
      emit_data = rdata_r;
    end else begin
      emit_data = dflt_r;
    end
  end

  assign sts.kind      = kind;
  assign sts.in_last   = in_data.in_last;
  assign sts.held_last = last_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.run_end   = (left_r == LW'(1)) || limit_hit;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    bytes_nxt     = bytes_r;
    finished_nxt  = finished_r;
    flag_nxt      = flag_r;
    expect_nxt    = expect_r;
    off_low_nxt   = off_low_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    lit_nxt       = lit_r;
    last_nxt      = last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cmd.accept) begin
      last_nxt = in_data.in_last;
      if (fin_eff) begin
        finished_nxt = 1'b1;
      end else if (expect_r) begin
        expect_nxt = 1'b0;
        src_nxt    = {in_data.in_byte[7:4], off_low_r};
        left_nxt   = {1'b0, in_data.in_byte[3:0]} + lzss_pkg::MIN_MATCH;
      end else if (!flag_r[8]) begin
        flag_nxt = {lzss_pkg::FLAG_FILL, in_data.in_byte};
      end else begin
        flag_nxt = flag_r >> 1;
        if (flag_r[0]) begin
          lit_nxt = in_data.in_byte;
        end else begin
          off_low_nxt = in_data.in_byte;
          expect_nxt  = 1'b1;
        end
      end
    end

    if (cmd.rd_issue) begin
      src_nxt = src_r + AW'(1);
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      wp_nxt        = wp_r + AW'(1);
      fill_nxt      = (fill_r == FW'(lzss_pkg::WIN_SIZE)) ? fill_r : fill_r + FW'(1);
      bytes_nxt     = bytes_inc;
      finished_nxt  = limit_hit;
      left_nxt      = left_r - LW'(1);
    end

    if (cmd.clear) begin
      bytes_nxt    = '0;
      finished_nxt = 1'b0;
      flag_nxt     = '0;
      expect_nxt   = 1'b0;
      wp_nxt       = lzss_pkg::WP_RESET;
      fill_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      bytes_r     <= '0;
      finished_r  <= 1'b0;
      flag_r      <= '0;
      expect_r    <= 1'b0;
      wp_r        <= lzss_pkg::WP_RESET;
      fill_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      bytes_r     <= bytes_nxt;
      finished_r  <= finished_nxt;
      flag_r      <= flag_nxt;
      expect_r    <= expect_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_low_r <= off_low_nxt;
    src_r     <= src_nxt;
    left_r    <= left_nxt;
    lit_r     <= lit_nxt;
    if (cmd.emit) begin
      out_r.out_byte      <= emit_data;
      out_r.run_last      <= cmd.emit_lit || sts.run_end;
      out_r.limit_reached <= (bytes_inc == limit_r);
    end
  end

  // window memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      win_mem[wp_r] <= emit_data;
    end
    if (cmd.rd_issue) begin
      rdata_r    <= win_mem[src_r];
      written_r  <= ({1'b0, rd_off} < fill_r);
      dflt_r     <= (src_r < lzss_pkg::WP_RESET) ? lzss_pkg::SPACE_CHR : 8'h00;
      // read hits the entry written this cycle
      fwd_r      <= cmd.emit && (src_r == wp_r);
      fwd_data_r <= emit_data;
    end
  end

endmodule

>>> hdl/lzss_window_decompressor.sv
// Literal: registered from lit_r to the output in ST_LIT once it is free. Reference: after
// its second request ST_RD issues the window read, then ST_EMIT registers one byte per cycle
// (length 3..18); output stalls hold the copy. Input reopens when a literal or copy ends; a
// flag byte or first reference byte keeps ST_IDLE. Window RAM: one write and one registered
// read per cycle, the read overlapping the write-back. Synchronous active-low reset: window
// reads as spaces/zero via a fill count, so no clearing pass; limit register resets to zero.
module lzss_window_decompressor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  lzss_pkg::ctl_cmd_t cmd;
  lzss_pkg::dp_sts_t  sts;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzss_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("emit into an occupied output register");

  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !cmd.emit_lit && sts.run_end) |=> in_ready)
    else $error("copy ended but input not reopened");

  a_ref_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.kind == lzss_pkg::KIND_REF) |=> (!in_ready && !cmd.emit))
    else $error("reference accepted without a window read");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!cmd.emit && !cmd.rd_issue))
    else $error("datapath active while idle");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 175;
  localparam int SETTLE       = 40;   // longest reference plus margin
  localparam int DRAIN        = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int PREDICT      = -1;
  localparam int N_STEPS      = 27;

  typedef enum logic [1:0] {SLOT_FLAG, SLOT_LIT, SLOT_REF_LO, SLOT_REF_HI} slot_t;

  typedef struct packed {
    logic        is_cfg;
    logic [31:0] cfg_val;
    logic [7:0]  stim_byte;
    logic        stim_last;
    int          typed_n;     // PREDICT: take the decoder model's bytes
    logic [7:0]  typed_byte;
    logic        typed_lim;
  } plan_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  lzss_pkg::in_item_t  in_req    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lzss_pkg::out_item_t out_res;
  logic                cfg_we    = 1'b0;
  logic [31:0]         cfg_wdata = '0;

  // decoder model state
  logic [7:0]  window_mem [lzss_pkg::WIN_SIZE];
  logic [11:0] window_pos;
  logic [15:0] flag_bits;
  logic        want_hi;
  logic [7:0]  pos_lo;
  logic [31:0] emitted;
  logic        halted;
  logic [31:0] out_limit;

  lzss_pkg::out_item_t expected_bytes [$];
  int          errors;
  int          items_sent;
  int          burst_left;
  logic        gappy;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          rx_mode;
  int          rx_left;
  logic        rx_next;
  int          idle_cycles;
  plan_row_t   steps [N_STEPS];

  lzss_window_decompressor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_history();
    for (int i = 0; i < lzss_pkg::WIN_SIZE; i++) begin
      window_mem[i] = (i < lzss_pkg::WIN_SIZE - lzss_pkg::MAX_MATCH) ?
                      lzss_pkg::SPACE_CHR : 8'h00;
    end
    window_pos = lzss_pkg::WP_RESET;
    flag_bits  = '0;
    want_hi    = 1'b0;
    pos_lo     = '0;
    emitted    = '0;
    halted     = 1'b0;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    lzss_pkg::out_item_t r;
    window_mem[window_pos] = v;
    window_pos = window_pos + 12'd1;
    emitted = emitted + 32'd1;
    r.out_byte      = v;
    r.run_last      = 1'b0;
    r.limit_reached = (emitted == out_limit);
    if (emitted >= out_limit) halted = 1'b1;
    expected_bytes.push_back(r);
  endfunction

  function automatic void decode_byte(lzss_pkg::in_item_t it);
    int                  first;
    int                  len;
    logic [11:0]         src;
    lzss_pkg::out_item_t r;
    first = expected_bytes.size();
    if (emitted >= out_limit) halted = 1'b1;
    if (!halted) begin
      if (want_hi) begin
        src = {it.in_byte[7:4], pos_lo};
        len = int'(it.in_byte[3:0]) + int'(lzss_pkg::MIN_MATCH);
        want_hi = 1'b0;
        // copy re-reads bytes it has just written when the source overlaps
        for (int k = 0; k < len && !halted; k++) begin
          push_byte(window_mem[src + 12'(k)]);
        end
      end else if (!flag_bits[8]) begin
        flag_bits = {lzss_pkg::FLAG_FILL, it.in_byte};
      end else if (flag_bits[0]) begin
        flag_bits = flag_bits >> 1;
        push_byte(it.in_byte);
      end else begin
        flag_bits = flag_bits >> 1;
        pos_lo = it.in_byte;
        want_hi = 1'b1;
      end
    end
    if (expected_bytes.size() > first) begin
      r = expected_bytes.pop_back();
      r.run_last = 1'b1;
      expected_bytes.push_back(r);
    end
    if (it.in_last) clear_history();
  endfunction

  // one request on the input channel, bursts with gaps between them
  task automatic send_byte(lzss_pkg::in_item_t it, int typed_n, logic [7:0] typed_byte,
                           logic typed_lim);
    int                  gap;
    int                  n0;
    lzss_pkg::out_item_t r;
    if (burst_left == 0) begin
      gap = gappy ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    n0 = expected_bytes.size();
    decode_byte(it);
    if (typed_n != PREDICT) begin
      while (expected_bytes.size() > n0) void'(expected_bytes.pop_back());
      for (int i = 0; i < typed_n; i++) begin
        r.out_byte      = typed_byte;
        r.run_last      = (i == typed_n - 1);
        r.limit_reached = typed_lim && (i == typed_n - 1);
        expected_bytes.push_back(r);
      end
    end
  endtask

  task automatic write_limit(logic [31:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // a byte with no output may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    out_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_stream();
    slot_t              kinds [$];
    logic [7:0]         flags [$];
    logic [7:0]         fb;
    logic [7:0]         hi_byte;
    logic [11:0]        src;
    lzss_pkg::in_item_t it;
    int                 groups;
    int                 stop_at;
    int                 fi;
    groups = $urandom_range(1, 4);
    hi_byte = '0;
    for (int g = 0; g < groups; g++) begin
      fb = 8'($urandom);
      flags.push_back(fb);
      kinds.push_back(SLOT_FLAG);
      for (int b = 0; b < 8; b++) begin
        if (fb[b]) begin
          kinds.push_back(SLOT_LIT);
        end else begin
          kinds.push_back(SLOT_REF_LO);
          kinds.push_back(SLOT_REF_HI);
        end
      end
    end
    stop_at = kinds.size();
    // now and then the stream is cut short, mid-group or mid-reference
    if ($urandom_range(0, 7) == 0) stop_at = $urandom_range(1, kinds.size());
    fi = 0;
    for (int i = 0; i < stop_at; i++) begin
      case (kinds[i])
        SLOT_FLAG: begin
          it.in_byte = flags[fi];
          fi++;
        end
        SLOT_LIT: it.in_byte = 8'($urandom);
        SLOT_REF_LO: begin
          if ($urandom_range(0, 1) == 1) begin
            src = window_pos - 12'($urandom_range(1, 40));
          end else begin
            src = 12'($urandom);
          end
          it.in_byte = src[7:0];
          hi_byte = {src[11:8], 4'($urandom)};
        end
        default: it.in_byte = hi_byte;
      endcase
      it.in_last = (i == stop_at - 1);
      send_byte(it, PREDICT, 8'h00, 1'b0);
    end
  endtask

  task automatic send_noise();
    lzss_pkg::in_item_t it;
    repeat ($urandom_range(1, 6)) begin
      it.in_byte = 8'($urandom);
      it.in_last = ($urandom_range(0, 7) == 0);
      send_byte(it, PREDICT, 8'h00, 1'b0);
    end
  endtask

  // result side: checker and ready pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %02h last %0b lim %0b",
                 $time, out_res.out_byte, out_res.run_last, out_res.limit_reached);
        errors++;
      end else begin
        lzss_pkg::out_item_t exp_r;
        exp_r = expected_bytes.pop_front();
        if (out_res.out_byte !== exp_r.out_byte) begin
          $display("%0t: out_byte mismatch, expected %02h, got %02h",
                   $time, exp_r.out_byte, out_res.out_byte);
          errors++;
        end
        if (out_res.run_last !== exp_r.run_last) begin
          $display("%0t: run_last mismatch, expected %0b, got %0b",
                   $time, exp_r.run_last, out_res.run_last);
          errors++;
        end
        if (out_res.limit_reached !== exp_r.limit_reached) begin
          $display("%0t: limit_reached mismatch, expected %0b, got %0b",
                   $time, exp_r.limit_reached, out_res.limit_reached);
          errors++;
        end
      end
    end

    if (hold_left > 0) begin
      hold_left--;
      rx_next = 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      rx_next = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       rx_next = 1'b1;
        1:       rx_next = ($urandom_range(0, 3) != 0);
        default: rx_next = (rx_left % 3 == 0);
      endcase
    end
    out_ready <= rx_next;
  end

  // watchdog: cycles without any input or output handshake or limit write
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [31:0]        lim;
    lzss_pkg::in_item_t it;
    int                 phase;

    errors = 0;
    items_sent = 0;
    burst_left = 0;
    gappy = 1'b1;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    rx_mode = 0;
    rx_left = 0;
    out_limit = '0;
    clear_history();

    steps = '{
      // limit still at its reset value of zero: everything is swallowed
      '{1'b0, 32'h0, 8'h12, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hED, 1'b1, 0, 8'h00, 1'b0},
      '{1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      // four references then four literals
      '{1'b0, 32'h0, 8'hF0, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hF0, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hF0, 1'b0, 3, 8'h00, 1'b0},        // zero tail of window
      '{1'b0, 32'h0, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h0F, 1'b0, 18, 8'h20, 1'b0},       // longest match of spaces
      '{1'b0, 32'h0, 8'hEE, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hFF, 1'b0, PREDICT, 8'h00, 1'b0},  // overlaps write position
      '{1'b0, 32'h0, 8'hFF, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hFF, 1'b0, PREDICT, 8'h00, 1'b0},  // wraps round the window
      '{1'b0, 32'h0, 8'h00, 1'b0, 1, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'hFF, 1'b0, 1, 8'hFF, 1'b0},
      '{1'b0, 32'h0, 8'h3C, 1'b0, 1, 8'h3C, 1'b0},
      '{1'b0, 32'h0, 8'hC3, 1'b1, 1, 8'hC3, 1'b0},
      // reference cut by the limit
      '{1'b1, 32'd5, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h01, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h41, 1'b0, 1, 8'h41, 1'b0},
      '{1'b0, 32'h0, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h0F, 1'b0, 4, 8'h20, 1'b1},
      '{1'b0, 32'h0, 8'h77, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h99, 1'b1, 0, 8'h00, 1'b0},
      // last flag on a flag byte and on the first half of a reference
      '{1'b1, 32'h8000_0000, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h00, 1'b1, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h00, 1'b0, 0, 8'h00, 1'b0},
      '{1'b0, 32'h0, 8'h10, 1'b1, 0, 8'h00, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        write_limit(steps[i].cfg_val);
      end else begin
        it.in_byte = steps[i].stim_byte;
        it.in_last = steps[i].stim_last;
        send_byte(it, steps[i].typed_n, steps[i].typed_byte, steps[i].typed_lim);
      end
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS || phase < 3) begin
      case ($urandom_range(0, 9))
        0:       lim = 32'h0;
        1:       lim = 32'h1;
        2, 3, 4: lim = $urandom_range(2, 80);
        5:       lim = $urandom;
        default: lim = 32'hFFFF_FFFF;
      endcase
      if (phase == 2) lim = 32'hFFFF_FFFF;
      write_limit(lim);
      gappy = ($urandom_range(0, 3) != 0);
      // long receiver hold-off while requests keep coming
      if (phase == 2) hold_requests <= hold_requests + 1;
      repeat ($urandom_range(1, 3)) begin
        if (phase != 2 && $urandom_range(0, 7) == 0) send_noise();
        else send_stream();
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
